### design/mtp_pkg.sv
// Shared constants and types for the mosaic tile placement block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package mtp_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int IDX_W          = 10;
	localparam int CNT_W          = 7;
	localparam int CFG_IDX_W      = 3;
	localparam int KEEP_BIT       = 1;

	localparam logic [1:0] MODE_FILL   = 2'd0;
	localparam logic [1:0] MODE_ASPECT = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOSAIC_W,
		REG_MOSAIC_H,
		REG_GRID_COLS,
		REG_GRID_ROWS,
		REG_BORDER_W,
		REG_BORDER_H,
		REG_ORIGIN_XY,
		REG_SCALE_MODE
	} mtp_reg_t;

	typedef struct packed {
		logic gt;
		logic zero;
	} mtp_fit_t;

endpackage

### design/mtp_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Standalone; used by the mosaic tile placement top level.
`timescale 1ns / 1ps

module mtp_div #(
	parameter int NW = 10,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	logic [NW-1:0] nq_s [1:NW];
	logic [DW-1:0] rm_s [1:NW];
	logic [DW-1:0] dn_s [1:NW-1];

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [NW-1:0] n_in;
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   t;
		logic [DW:0]   dif;
		logic          ge;

		if (i == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign n_in = nq_s[i];
			assign r_in = rm_s[i];
			assign d_in = dn_s[i];
		end

		assign t   = {r_in, n_in[NW-1]};
		assign dif = t - {1'b0, d_in};
		assign ge  = (t >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[i+1] <= {n_in[NW-2:0], ge};
				rm_s[i+1] <= ge ? dif[DW-1:0] : t[DW-1:0];
			end
		end

		if (i < NW - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					dn_s[i+1] <= d_in;
				end
			end
		end
	end

	assign quo = nq_s[NW];
	assign rem = rm_s[NW];

endmodule

### design/mosaic_tile_placement.sv
// Mosaic tile placement: top level, register file and placement pipeline.
// Depends on mtp_pkg and mtp_div.
`timescale 1ns / 1ps
//
// Usage:
// Each word on the s_ channel describes one tile: slot index, source size and
// an optional fixed position (s_tuser). The m_ channel returns one word per
// tile with its top-left corner and scaled size, in input order.
// The cfg_ channel writes the eight layout registers by index; write them
// only while no tile is in flight. cfg_ready is always high.
// The tile path runs through bit-per-stage dividers for slot row/column,
// border offset and aspect fit. Throughput is one tile per cycle while
// m_tvalid is not held waiting on m_tready.
// Reset clears all valid bits and loads the register defaults (100 x 100
// mosaic, 2 x 2 grid, no borders, origin 0, fill mode).
// When m_tready is low with a word waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.

module mosaic_tile_placement
	import mtp_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// tile_index, src_width, src_height, fixed_x, fixed_y
	input  logic [((4*COORD_BITS+12+7)/8)*8-1:0]  s_tdata,
	// fixed_valid
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// tile_x, tile_y, tile_width, tile_height
	output logic [((4*COORD_BITS+2+7)/8)*8-1:0]   m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [2*COORD_BITS-1:0]               cfg_data
);

	localparam int CB    = COORD_BITS;
	localparam int PB    = CB + 1;
	localparam int OUT_W = ((4*CB+2+7)/8)*8;
	localparam int BW3   = CB + CNT_W;
	localparam int SW3   = CB + 9;
	localparam int OP    = (2*CB > 25) ? 2*CB - 25 : 0;
	localparam int OS    = (2*CB < 25) ? 25 - 2*CB : 0;
	localparam int FIN   = 29 + CB + OP;
	localparam int SM    = 2 + CB + OS;
	localparam logic [PB-1:0] PMAX = {PB{1'b1}};

	logic [CB-1:0]    wid_q, hgt_q, bw_q, bh_q;
	logic [CNT_W-1:0] cols_q, rows_q;
	logic [2*CB-1:0]  org_q;
	logic [1:0]       mode_q;
	logic [CNT_W-1:0] cols_e, rows_e;

	logic             adv;
	logic [FIN:0]     vld_s;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [IDX_W-1:0] idx_s [0:OP];
	logic [CB-1:0]    sw_s  [0:FIN];
	logic [CB-1:0]    sh_s  [0:FIN];
	logic             fix_s [0:FIN];
	logic [PB-1:0]    fx_s  [0:FIN];
	logic [PB-1:0]    fy_s  [0:FIN];

	logic [BW3-1:0]   usedw_q, usedh_q;
	logic [CB-1:0]    numw_q, numh_q;
	logic [CB-1:0]    cw, ch, wq, hq;

	logic [IDX_W-1:0] iq;
	logic [CNT_W-1:0] ir, rr;
	logic [CNT_W-1:0] col_d [0:IDX_W-1];
	logic [BW3-1:0]   ax_d [0:BW3];
	logic [BW3-1:0]   ay_d [0:BW3];
	logic [BW3-1:0]   bx_s, by_s, qx, qy;
	logic [SW3-1:0]   sx, sy;
	logic [PB-1:0]    px_s, py_s;

	logic [2*CB-1:0]  p1_s, p2_s, anum_s, aq;
	logic [CB-1:0]    aden_s;
	mtp_fit_t         fit_d [0:2*CB];

	logic [CB-1:0]    tw, th;
	logic [PB-1:0]    tx, ty;

	// register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q  <= CB'(100);
			hgt_q  <= CB'(100);
			cols_q <= CNT_W'(2);
			rows_q <= CNT_W'(2);
			bw_q   <= '0;
			bh_q   <= '0;
			org_q  <= '0;
			mode_q <= MODE_FILL;
		end else if (cfg_valid) begin
			unique case (mtp_reg_t'(cfg_index))
				REG_MOSAIC_W:   wid_q  <= cfg_data[CB-1:0];
				REG_MOSAIC_H:   hgt_q  <= cfg_data[CB-1:0];
				REG_GRID_COLS:  cols_q <= cfg_data[CNT_W-1:0];
				REG_GRID_ROWS:  rows_q <= cfg_data[CNT_W-1:0];
				REG_BORDER_W:   bw_q   <= cfg_data[CB-1:0];
				REG_BORDER_H:   bh_q   <= cfg_data[CB-1:0];
				REG_ORIGIN_XY:  org_q  <= cfg_data;
				REG_SCALE_MODE: mode_q <= cfg_data[1:0];
				default:        mode_q <= mode_q;
			endcase
		end
	end

	assign cols_e = (cols_q == '0) ? CNT_W'(1) : cols_q;
	assign rows_e = (rows_q == '0) ? CNT_W'(1) : rows_q;

	// handshake
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			vld_s      <= {vld_s[FIN-1:0], s_tvalid};
			m_tvalid_q <= vld_s[FIN];
		end
	end

	// item shift line
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s[0] <= s_tdata[IDX_W-1:0];
			sw_s[0]  <= s_tdata[IDX_W +: CB];
			sh_s[0]  <= s_tdata[IDX_W+CB +: CB];
			fx_s[0]  <= s_tdata[IDX_W+2*CB +: PB];
			fy_s[0]  <= s_tdata[IDX_W+2*CB+PB +: PB];
			fix_s[0] <= s_tuser;
			for (int i = 1; i <= OP; i++) begin
				idx_s[i] <= idx_s[i-1];
			end
			for (int i = 1; i <= FIN; i++) begin
				sw_s[i]  <= sw_s[i-1];
				sh_s[i]  <= sh_s[i-1];
				fx_s[i]  <= fx_s[i-1];
				fy_s[i]  <= fy_s[i-1];
				fix_s[i] <= fix_s[i-1];
			end
		end
	end

	// cell size and pitch, from the registers alone
	always_ff @(posedge clk) begin
		usedw_q <= BW3'(cols_e - CNT_W'(1)) * BW3'(bw_q);
		usedh_q <= BW3'(rows_e - CNT_W'(1)) * BW3'(bh_q);
		numw_q  <= (usedw_q >= BW3'(wid_q)) ? '0 : CB'(BW3'(wid_q) - usedw_q);
		numh_q  <= (usedh_q >= BW3'(hgt_q)) ? '0 : CB'(BW3'(hgt_q) - usedh_q);
	end

	mtp_div #(.NW(CB), .DW(CNT_W)) u_cw (
		.clk(clk), .en(1'b1), .num(numw_q), .den(cols_e), .quo(cw), .rem()
	);
	mtp_div #(.NW(CB), .DW(CNT_W)) u_ch (
		.clk(clk), .en(1'b1), .num(numh_q), .den(rows_e), .quo(ch), .rem()
	);
	mtp_div #(.NW(CB), .DW(CNT_W)) u_wq (
		.clk(clk), .en(1'b1), .num(wid_q), .den(cols_e), .quo(wq), .rem()
	);
	mtp_div #(.NW(CB), .DW(CNT_W)) u_hq (
		.clk(clk), .en(1'b1), .num(hgt_q), .den(rows_e), .quo(hq), .rem()
	);

	// grid row and column
	mtp_div #(.NW(IDX_W), .DW(CNT_W)) u_ix (
		.clk(clk), .en(adv), .num(idx_s[OP]), .den(cols_e), .quo(iq), .rem(ir)
	);
	mtp_div #(.NW(IDX_W), .DW(CNT_W)) u_iy (
		.clk(clk), .en(adv), .num(iq), .den(rows_e), .quo(), .rem(rr)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			col_d[0] <= ir;
			for (int i = 1; i < IDX_W; i++) begin
				col_d[i] <= col_d[i-1];
			end
			ax_d[0] <= BW3'(col_d[IDX_W-1]) * BW3'(wq);
			ay_d[0] <= BW3'(rr) * BW3'(hq);
			bx_s    <= BW3'(col_d[IDX_W-1]) * BW3'(bw_q);
			by_s    <= BW3'(rr) * BW3'(bh_q);
			for (int i = 1; i <= BW3; i++) begin
				ax_d[i] <= ax_d[i-1];
				ay_d[i] <= ay_d[i-1];
			end
		end
	end

	mtp_div #(.NW(BW3), .DW(CNT_W)) u_bx (
		.clk(clk), .en(adv), .num(bx_s), .den(cols_e), .quo(qx), .rem()
	);
	mtp_div #(.NW(BW3), .DW(CNT_W)) u_by (
		.clk(clk), .en(adv), .num(by_s), .den(rows_e), .quo(qy), .rem()
	);

	assign sx = SW3'(org_q[CB-1:0]) + SW3'(ax_d[BW3]) + SW3'(qx);
	assign sy = SW3'(org_q[2*CB-1:CB]) + SW3'(ay_d[BW3]) + SW3'(qy);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s <= (sx > SW3'(PMAX)) ? PMAX : sx[PB-1:0];
			py_s <= (sy > SW3'(PMAX)) ? PMAX : sy[PB-1:0];
		end
	end

	// aspect fit
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s            <= (2*CB)'(cw) * (2*CB)'(sh_s[SM]);
			p2_s            <= (2*CB)'(sw_s[SM]) * (2*CB)'(ch);
			fit_d[0].gt     <= (p1_s > p2_s);
			fit_d[0].zero   <= (sw_s[SM+1] == '0) || (sh_s[SM+1] == '0);
			anum_s          <= (p1_s > p2_s) ? p2_s : p1_s;
			aden_s          <= (p1_s > p2_s) ? sh_s[SM+1] : sw_s[SM+1];
			for (int i = 1; i <= 2*CB; i++) begin
				fit_d[i] <= fit_d[i-1];
			end
		end
	end

	mtp_div #(.NW(2*CB), .DW(CB)) u_as (
		.clk(clk), .en(adv), .num(anum_s), .den(aden_s), .quo(aq), .rem()
	);

	// result word
	always_comb begin
		priority if (mode_q[KEEP_BIT]) begin
			tw = sw_s[FIN];
			th = sh_s[FIN];
		end else if (mode_q == MODE_ASPECT) begin
			priority if (fit_d[2*CB].zero) begin
				tw = '0;
				th = '0;
			end else if (fit_d[2*CB].gt) begin
				tw = aq[CB-1:0];
				th = ch;
			end else begin
				tw = cw;
				th = aq[CB-1:0];
			end
		end else begin
			tw = cw;
			th = ch;
		end
		tx = fix_s[FIN] ? fx_s[FIN] : px_s;
		ty = fix_s[FIN] ? fy_s[FIN] : py_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= OUT_W'({th, tw, ty, tx});
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	a_fit_in_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[FIN] && adv && mode_q == MODE_ASPECT && !fit_d[2*CB].zero)
		|=> (m_tdata[2*CB+2 +: CB] <= $past(cw)) && (m_tdata[3*CB+2 +: CB] <= $past(ch)))
		else $error("aspect fit exceeds cell");

	a_grid_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[FIN] && adv && !fix_s[FIN])
		|=> m_tdata[PB-1:0] >= $past(PB'(org_q[CB-1:0])))
		else $error("grid x left of mosaic origin");

	a_fixed_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[FIN] && adv && fix_s[FIN])
		|=> (m_tdata[PB-1:0] == $past(fx_s[FIN])) && (m_tdata[PB +: PB] == $past(fy_s[FIN])))
		else $error("fixed position not passed through");

endmodule
